/* sv/rrps_pkg.sv */
// Shared types and constants for the round-robin process scheduler.
package rrps_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_PCOUNT  = 1'b1;

    localparam logic [15:0] QUANTUM_RST = 16'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
    } t_in;

    typedef struct packed {
        logic        busy_res;
        logic [5:0]  running_proc;
        logic        finished_valid;
        logic [5:0]  finished_proc;
        logic [23:0] wait_time;
        logic        all_done;
        logic [23:0] current_time;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_START,
        OP_SCAN_WORK,
        OP_RD_CUR,
        OP_CHK_CUR,
        OP_POP,
        OP_CHK_POP,
        OP_RUN,
        OP_TICK,
        OP_END,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic any_work;
        logic cur_ok;
        logic pop_ok;
        logic fifo_ne;
        logic out_free;
    } t_sts;

endpackage

/* sv/round_robin_process_scheduler.sv */
// Top level of the round-robin process scheduler.
// One item is handled at a time. Every item ends with a scan of the n active slots
// (n = min(process_count, MAX_PROCS)) through the single read port of the slot tables,
// one slot per cycle, to find all_done; a tick item also scans once to check for
// remaining work and, if any remains, once to enqueue arrivals. An item that ends
// while an earlier result is still untaken waits for that result to be taken.
// The result sits in an output register, so the next item is taken while it waits.
module round_robin_process_scheduler #(
    parameter int MAX_PROCS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrps_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrps_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    rrps_pkg::t_cmd w_cmd;
    rrps_pkg::t_sts w_sts;

    rrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_in.kind),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rrps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

/* sv/rrps_dp.sv */
// Datapath: slot tables, ready FIFO, slot scanner, schedule registers, result register.
module rrps_dp #(
    parameter int MAX_PROCS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rrps_pkg::t_cmd i_cmd,
    output rrps_pkg::t_sts o_sts,
    input  rrps_pkg::t_in i_in,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rrps_pkg::t_out o_out
);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int NW = $clog2(MAX_PROCS + 1);

    logic [31:0]   mem_ab  [MAX_PROCS];
    logic [15:0]   mem_rem [MAX_PROCS];
    logic [IW-1:0] mem_fifo[MAX_PROCS];

    logic [15:0]   r_quantum;
    logic [6:0]    r_pcount;
    logic [IW-1:0] r_head;
    logic [NW-1:0] r_count;
    logic [IW-1:0] r_cur;
    logic          r_cur_vld;
    logic [15:0]   r_slice;
    logic [23:0]   r_time;
    logic [IW-1:0] r_sc_idx;
    logic [IW-1:0] r_sc_didx;
    logic          r_sc_act;
    logic          r_sc_vld;
    logic          r_sc_arr;
    logic          r_any;
    logic [31:0]   r_q_ab;
    logic [15:0]   r_q_rem;
    logic [IW-1:0] r_fifo_q;
    logic [IW-1:0] r_cand;
    logic [15:0]   r_p_arr;
    logic [15:0]   r_p_bur;
    logic [15:0]   r_p_rem;
    logic          r_last;
    logic          r_busy;
    logic [5:0]    r_run_p;
    logic          r_fin;
    logic [5:0]    r_fin_p;
    logic [23:0]   r_wait;
    logic          r_out_valid;
    rrps_pkg::t_out r_out;

    logic [NW-1:0] w_n;
    logic [IW-1:0] w_addr;
    logic [NW:0]   w_sum;
    logic [IW-1:0] w_tail;
    logic          w_full;
    logic          w_sc_push;
    logic          w_end_push;
    logic [IW-1:0] w_push_val;
    logic          w_scan_go;
    logic          w_ld_ok;
    logic          w_rem_we;
    logic [IW-1:0] w_rem_wa;
    logic [15:0]   w_rem_wd;

    assign w_n = (int'(r_pcount) > MAX_PROCS) ? NW'(MAX_PROCS) : NW'(r_pcount);
    assign w_addr = r_sc_act ? r_sc_idx :
                    (i_cmd.op == rrps_pkg::OP_POP) ? r_fifo_q : r_cur;
    assign w_sum = (NW + 1)'(r_head) + (NW + 1)'(r_count);
    assign w_tail = (w_sum >= (NW + 1)'(MAX_PROCS)) ?
                    IW'(w_sum - (NW + 1)'(MAX_PROCS)) : IW'(w_sum);
    assign w_full = (r_count == NW'(MAX_PROCS));
    assign w_sc_push = r_sc_vld && r_sc_arr && (r_q_rem != 16'd0) &&
                       ({8'd0, r_q_ab[31:16]} == r_time);
    assign w_end_push = (i_cmd.op == rrps_pkg::OP_END) && !r_last && (r_slice == 16'd0);
    assign w_push_val = w_sc_push ? r_sc_didx : r_cur;
    assign w_scan_go = (i_cmd.op == rrps_pkg::OP_START) || (i_cmd.op == rrps_pkg::OP_RUN) ||
                       (i_cmd.op == rrps_pkg::OP_TICK) ||
                       (i_cmd.op == rrps_pkg::OP_SCAN_WORK);
    assign w_ld_ok = (i_cmd.op == rrps_pkg::OP_LOAD) && (int'(i_in.slot) < MAX_PROCS);
    assign w_rem_we = w_ld_ok || (i_cmd.op == rrps_pkg::OP_RUN);
    assign w_rem_wa = w_ld_ok ? IW'(i_in.slot) : r_cur;
    assign w_rem_wd = w_ld_ok ? i_in.burst_time : r_p_rem - 16'd1;

    always_ff @(posedge i_clk) begin
        if (w_ld_ok) begin
            mem_ab[IW'(i_in.slot)] <= {i_in.arrival_time, i_in.burst_time};
        end
        if (w_rem_we) begin
            mem_rem[w_rem_wa] <= w_rem_wd;
        end
        if ((w_sc_push || w_end_push) && !w_full) begin
            mem_fifo[w_tail] <= w_push_val;
        end
        r_q_ab   <= mem_ab[w_addr];
        r_q_rem  <= mem_rem[w_addr];
        r_fifo_q <= mem_fifo[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum   <= rrps_pkg::QUANTUM_RST;
            r_pcount    <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_vld   <= 1'b0;
            r_slice     <= '0;
            r_time      <= '0;
            r_sc_idx    <= '0;
            r_sc_didx   <= '0;
            r_sc_act    <= 1'b0;
            r_sc_vld    <= 1'b0;
            r_sc_arr    <= 1'b0;
            r_any       <= 1'b0;
            r_last      <= 1'b0;
            r_busy      <= 1'b0;
            r_run_p     <= '0;
            r_fin       <= 1'b0;
            r_fin_p     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == rrps_pkg::CFG_QUANTUM) begin
                    r_quantum <= i_cfg_data;
                end else begin
                    r_pcount <= i_cfg_data[6:0];
                end
            end
            if (i_cmd.clr) begin
                r_busy  <= 1'b0;
                r_run_p <= '0;
                r_fin   <= 1'b0;
                r_fin_p <= '0;
                r_wait  <= '0;
            end
            // slot scanner: one slot read per cycle, evaluated in the cycle after its read
            r_sc_vld  <= r_sc_act;
            r_sc_didx <= r_sc_idx;
            if (w_scan_go) begin
                r_sc_idx <= '0;
                r_sc_act <= (w_n != '0);
                r_sc_arr <= (i_cmd.op != rrps_pkg::OP_SCAN_WORK);
                r_any    <= 1'b0;
            end else if (r_sc_act) begin
                r_sc_idx <= r_sc_idx + 1'b1;
                if (NW'(r_sc_idx) + NW'(1) == w_n) begin
                    r_sc_act <= 1'b0;
                end
            end
            if (r_sc_vld && (r_q_rem != 16'd0)) begin
                r_any <= 1'b1;
            end
            if ((w_sc_push || w_end_push) && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            case (i_cmd.op)
                rrps_pkg::OP_START: begin
                    r_time    <= '0;
                    r_head    <= '0;
                    r_count   <= '0;
                    r_cur_vld <= 1'b0;
                    r_cur     <= '0;
                    r_slice   <= '0;
                end
                rrps_pkg::OP_CHK_CUR: begin
                    r_p_arr <= r_q_ab[31:16];
                    r_p_bur <= r_q_ab[15:0];
                    r_p_rem <= r_q_rem;
                    if (!o_sts.cur_ok) begin
                        r_cur_vld <= 1'b0;
                    end
                end
                rrps_pkg::OP_POP: begin
                    r_cand  <= r_fifo_q;
                    r_head  <= (int'(r_head) == MAX_PROCS - 1) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                end
                rrps_pkg::OP_CHK_POP: begin
                    r_p_arr <= r_q_ab[31:16];
                    r_p_bur <= r_q_ab[15:0];
                    r_p_rem <= r_q_rem;
                    if (o_sts.pop_ok) begin
                        r_cur     <= r_cand;
                        r_cur_vld <= 1'b1;
                        r_slice   <= (r_quantum == 16'd0) ? 16'd1 : r_quantum;
                    end
                end
                rrps_pkg::OP_RUN: begin
                    r_busy  <= 1'b1;
                    r_run_p <= 6'(r_cur);
                    r_last  <= (r_p_rem == 16'd1);
                    r_slice <= r_slice - 16'd1;
                    r_time  <= r_time + 24'd1;
                end
                rrps_pkg::OP_TICK: begin
                    r_time <= r_time + 24'd1;
                end
                rrps_pkg::OP_END: begin
                    if (r_last) begin
                        r_fin     <= 1'b1;
                        r_fin_p   <= 6'(r_cur);
                        r_wait    <= r_time - {8'd0, r_p_arr} - {8'd0, r_p_bur};
                        r_cur_vld <= 1'b0;
                    end else if (r_slice == 16'd0) begin
                        r_cur_vld <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == rrps_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rrps_pkg::OP_EMIT) begin
            r_out.busy_res       <= r_busy;
            r_out.running_proc   <= r_run_p;
            r_out.finished_valid <= r_fin;
            r_out.finished_proc  <= r_fin_p;
            r_out.wait_time      <= r_wait;
            r_out.all_done       <= ~r_any;
            r_out.current_time   <= r_time;
        end
    end

    assign o_sts.scan_done = !r_sc_act && !r_sc_vld;
    assign o_sts.any_work  = r_any;
    assign o_sts.cur_ok    = r_cur_vld && (NW'(r_cur) < w_n) && (r_q_rem != 16'd0);
    assign o_sts.pop_ok    = (NW'(r_cand) < w_n) && (r_q_rem != 16'd0);
    assign o_sts.fifo_ne   = (r_count != '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
endmodule

/* sv/rrps_ctrl.sv */
// Controller: sequences load, start and tick items over the datapath; an item of unknown kind only rescans and emits.
module rrps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_kind,
    input  rrps_pkg::t_sts i_sts,
    output rrps_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_WL, S_CUR, S_CUR_CHK, S_POP, S_POP_CHK, S_RUN, S_RUN_ARR,
        S_END, S_TICK, S_ARR, S_FIN, S_AD, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = rrps_pkg::OP_NOP;
        o_cmd.clr  = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.clr = 1'b1;
                    case (i_kind)
                        rrps_pkg::KIND_LOAD: begin
                            o_cmd.op = rrps_pkg::OP_LOAD;
                            n_state  = S_FIN;
                        end
                        rrps_pkg::KIND_START: begin
                            o_cmd.op = rrps_pkg::OP_START;
                            n_state  = S_ARR;
                        end
                        rrps_pkg::KIND_TICK: begin
                            o_cmd.op = rrps_pkg::OP_SCAN_WORK;
                            n_state  = S_WL;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_WL: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.any_work ? S_CUR : S_FIN;
                end
            end
            S_CUR: begin
                o_cmd.op = rrps_pkg::OP_RD_CUR;
                n_state  = S_CUR_CHK;
            end
            S_CUR_CHK: begin
                o_cmd.op = rrps_pkg::OP_CHK_CUR;
                if (i_sts.cur_ok) begin
                    n_state = S_RUN;
                end else if (i_sts.fifo_ne) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_TICK;
                end
            end
            S_POP: begin
                o_cmd.op = rrps_pkg::OP_POP;
                n_state  = S_POP_CHK;
            end
            S_POP_CHK: begin
                o_cmd.op = rrps_pkg::OP_CHK_POP;
                n_state  = i_sts.pop_ok ? S_RUN : S_TICK;
            end
            S_RUN: begin
                o_cmd.op = rrps_pkg::OP_RUN;
                n_state  = S_RUN_ARR;
            end
            S_RUN_ARR: begin
                if (i_sts.scan_done) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                o_cmd.op = rrps_pkg::OP_END;
                n_state  = S_FIN;
            end
            S_TICK: begin
                o_cmd.op = rrps_pkg::OP_TICK;
                n_state  = S_ARR;
            end
            S_ARR: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.op = rrps_pkg::OP_SCAN_WORK;
                n_state  = S_AD;
            end
            S_AD: begin
                if (i_sts.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = rrps_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

/* dv/rrps_checker.sv */
// Scoreboard for the round-robin scheduler: predicts each result and compares it.
`timescale 1ns / 100ps

module rrps_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  rrps_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  rrps_pkg::t_out i_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_results,
    output int             o_finished
);

    localparam int NPROC = 64;

    logic [15:0]    arr_tab [NPROC];
    logic [15:0]    bur_tab [NPROC];
    logic [15:0]    rem_tab [NPROC];
    logic [5:0]     ready_q [NPROC];
    int             q_head;
    int             q_cnt;
    logic [5:0]     cur;
    bit             cur_v;
    logic [15:0]    slice;
    logic [23:0]    sched_t;
    logic [15:0]    quantum;
    logic [6:0]     pcount;
    rrps_pkg::t_out expected_q[$];

    function automatic int active_n();
        return (pcount > NPROC) ? NPROC : int'(pcount);
    endfunction

    function automatic bit any_work();
        for (int i = 0; i < active_n(); i++) begin
            if (rem_tab[i] != 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit can_run(logic [5:0] p);
        return (int'(p) < active_n()) && (rem_tab[p] != 0);
    endfunction

    function automatic void push_ready(logic [5:0] p);
        if (q_cnt >= NPROC) return;
        ready_q[(q_head + q_cnt) % NPROC] = p;
        q_cnt++;
    endfunction

    function automatic void add_arrivals();
        for (int i = 0; i < active_n(); i++) begin
            if (arr_tab[i] == sched_t && rem_tab[i] != 0) push_ready(6'(i));
        end
    endfunction

    function automatic rrps_pkg::t_out schedule_item(rrps_pkg::t_in it);
        rrps_pkg::t_out r;
        logic [5:0]     p;
        r = '0;
        case (it.kind)
            rrps_pkg::KIND_LOAD: begin
                arr_tab[it.slot] = it.arrival_time;
                bur_tab[it.slot] = it.burst_time;
                rem_tab[it.slot] = it.burst_time;
            end
            rrps_pkg::KIND_START: begin
                sched_t = '0;
                q_head = 0;
                q_cnt = 0;
                cur_v = 1'b0;
                cur = '0;
                slice = '0;
                add_arrivals();
            end
            rrps_pkg::KIND_TICK: begin
                if (any_work()) begin
                    if (cur_v && !can_run(cur)) cur_v = 1'b0;
                    if (!cur_v && q_cnt != 0) begin
                        p = ready_q[q_head];
                        q_head = (q_head + 1) % NPROC;
                        q_cnt--;
                        if (can_run(p)) begin
                            cur = p;
                            cur_v = 1'b1;
                            slice = (quantum == 0) ? 16'd1 : quantum;
                        end
                    end
                    if (cur_v) begin
                        p = cur;
                        r.busy_res = 1'b1;
                        r.running_proc = p;
                        rem_tab[p] = rem_tab[p] - 16'd1;
                        slice = slice - 16'd1;
                        sched_t = sched_t + 24'd1;
                        add_arrivals();
                        if (rem_tab[p] == 0) begin
                            r.finished_valid = 1'b1;
                            r.finished_proc = p;
                            r.wait_time = sched_t - 24'(arr_tab[p]) - 24'(bur_tab[p]);
                            cur_v = 1'b0;
                        end else if (slice == 0) begin
                            push_ready(p);
                            cur_v = 1'b0;
                        end
                    end else begin
                        sched_t = sched_t + 24'd1;
                        add_arrivals();
                    end
                end
            end
            default: ;
        endcase
        r.all_done = !any_work();
        r.current_time = sched_t;
        return r;
    endfunction

    task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        rrps_pkg::t_out e;
        if (!i_rst_n) begin
            for (int i = 0; i < NPROC; i++) begin
                arr_tab[i] = '0;
                bur_tab[i] = '0;
                rem_tab[i] = '0;
                ready_q[i] = '0;
            end
            q_head = 0;
            q_cnt = 0;
            cur = '0;
            cur_v = 1'b0;
            slice = '0;
            sched_t = '0;
            quantum = rrps_pkg::QUANTUM_RST;
            pcount = '0;
            expected_q.delete();
            o_errors = 0;
            o_results = 0;
            o_finished = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == rrps_pkg::CFG_QUANTUM) quantum = i_cfg_data;
                else pcount = i_cfg_data[6:0];
            end
            if (i_in_valid && i_in_ready) expected_q.push_back(schedule_item(i_in));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, i_out);
                    o_errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.finished_valid) o_finished++;
                    check_field("busy_res", 24'(e.busy_res), 24'(i_out.busy_res));
                    check_field("running_proc", 24'(e.running_proc), 24'(i_out.running_proc));
                    check_field("finished_valid", 24'(e.finished_valid),
                                24'(i_out.finished_valid));
                    check_field("finished_proc", 24'(e.finished_proc),
                                24'(i_out.finished_proc));
                    check_field("wait_time", e.wait_time, i_out.wait_time);
                    check_field("all_done", 24'(e.all_done), 24'(i_out.all_done));
                    check_field("current_time", e.current_time, i_out.current_time);
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

/* dv/tb.sv */
// Testbench top: drives items and register writes into the scheduler, gives the verdict.
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] KIND_BAD = 2'd3;
    localparam int SETTLE = 230;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    rrps_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_ready;
    rrps_pkg::t_out o_out;
    logic           i_cfg_we;
    logic           i_cfg_idx;
    logic [15:0]    i_cfg_data;

    int errors, pending, results, finished;
    int in_acc;
    int sent;
    int idle_pct, stall_pct;
    bit hold_req;
    bit all_loaded;

    round_robin_process_scheduler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    rrps_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_finished(finished)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) in_acc <= 0;
        else if (i_in_valid && o_in_ready) in_acc <= in_acc + 1;
    end

    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send(logic [1:0] kind, logic [5:0] slot, logic [15:0] arr, logic [15:0] bur);
        int tgt;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        tgt = in_acc + 1;
        i_in_valid <= 1'b1;
        i_in <= '{kind: kind, slot: slot, arrival_time: arr, burst_time: bur};
        do @(negedge i_clk); while (in_acc != tgt);
        sent++;
    endtask

    task automatic tick();
        send(rrps_pkg::KIND_TICK, 6'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] q, logic [15:0] pc);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= rrps_pkg::CFG_QUANTUM;
        i_cfg_data <= q;
        @(negedge i_clk);
        i_cfg_idx <= rrps_pkg::CFG_PCOUNT;
        i_cfg_data <= pc;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_set(int n, logic [15:0] q, logic [15:0] pc, bit stress);
        int need, maxa, nticks, r;
        logic [15:0] a, b;
        need = 0;
        maxa = 0;
        for (int i = 0; i < n; i++) begin
            a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, n + 6));
            r = $urandom_range(19);
            b = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 6));
            if (a < 200 && a > maxa) maxa = a;
            need += (b > 100) ? 100 : b;
            send(rrps_pkg::KIND_LOAD, 6'(i), a, b);
        end
        drain();
        write_regs(q, pc);
        send(rrps_pkg::KIND_START, 6'($urandom), 16'($urandom), 16'($urandom));
        nticks = need + maxa + 3;
        if (nticks > 80) nticks = 80;
        for (int t = 0; t < nticks; t++) begin
            if (stress && t == 3) hold_req = 1'b1;
            if (stress && t == nticks / 2) wait_results();
            r = $urandom_range(39);
            if (r == 0) send(KIND_BAD, 6'($urandom), 16'($urandom), 16'($urandom));
            else if (r == 1) send(rrps_pkg::KIND_LOAD, 6'($urandom_range(0, n - 1)),
                                  16'($urandom_range(0, 20)), 16'($urandom_range(0, 4)));
            else if (r == 2) send(rrps_pkg::KIND_START, 6'($urandom), 16'($urandom),
                                  16'($urandom));
            else tick();
        end
        drain();
    endtask

    initial begin
        int scen, n, r;
        logic [15:0] q, pc;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rrps_pkg::CFG_QUANTUM;
        i_cfg_data = '0;
        hold_req = 1'b0;
        all_loaded = 1'b0;
        sent = 0;
        idle_pct = 9;
        stall_pct = 53;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no slots taking part, unknown kind, then a small set with extremes
        tick();
        send(KIND_BAD, 6'h3f, 16'hffff, 16'hffff);
        send(rrps_pkg::KIND_LOAD, 6'd0, 16'd0, 16'd3);
        send(rrps_pkg::KIND_LOAD, 6'd1, 16'd0, 16'd0);
        send(rrps_pkg::KIND_LOAD, 6'd2, 16'd2, 16'd1);
        send(rrps_pkg::KIND_LOAD, 6'd3, 16'hffff, 16'hffff);
        send(rrps_pkg::KIND_LOAD, 6'd4, 16'd1, 16'd2);
        send(rrps_pkg::KIND_LOAD, 6'd63, 16'd0, 16'd0);
        drain();
        write_regs(16'd1, 16'd5);
        send(rrps_pkg::KIND_START, 6'd0, 16'd0, 16'd0);
        repeat (5) tick();
        send(rrps_pkg::KIND_LOAD, 6'd0, 16'd0, 16'd0);
        repeat (3) tick();
        drain();
        write_regs(16'd0, 16'd5);
        send(rrps_pkg::KIND_START, 6'h3f, 16'hffff, 16'hffff);
        repeat (4) tick();
        drain();

        scen = 0;
        while (sent < 1100) begin
            if (sent < 400) begin
                idle_pct = 9;
                stall_pct = 53;
            end else if (sent < 800) begin
                idle_pct = 53;
                stall_pct = 9;
            end else begin
                idle_pct = 0;
                stall_pct = 0;
            end
            r = $urandom_range(19);
            if (scen == 5 || scen == 25) n = 64;
            else if (r < 2) n = $urandom_range(9, 20);
            else n = $urandom_range(1, 8);
            r = $urandom_range(9);
            q = (r == 0) ? 16'd1 : (r == 1) ? 16'hffff : (r == 2) ? 16'd0 :
                (r == 3) ? 16'($urandom) : 16'($urandom_range(1, 8));
            pc = 16'(n);
            if (all_loaded && $urandom_range(3) == 0)
                pc = (scen % 2) ? 16'd127 : 16'($urandom_range(65, 126));
            if (pc[6:0] == 7'd64) pc = pc | 16'hff80;
            run_set(n, q, pc, scen == 3 || scen == 20);
            if (n == 64) all_loaded = 1'b1;
            scen++;
        end

        drain();
        $display("tb: %0d items in %0d schedule sets, %0d results checked, %0d completions",
                 sent, scen, results, finished);
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/rrps_pkg.sv
sv/rrps_dp.sv
sv/rrps_ctrl.sv
sv/round_robin_process_scheduler.sv
dv/rrps_checker.sv
dv/tb.sv
